// ===== hw/rtl/breakpoint_table_interpolator_assert.svh =====
// Assertion macros shared by the breakpoint table interpolator RTL.
// Every macro samples on clk and is switched off while arst_n is low.
`ifndef BREAKPOINT_TABLE_INTERPOLATOR_ASSERT_SVH
`define BREAKPOINT_TABLE_INTERPOLATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BTI_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BTI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/bti_pkg.sv =====
// Shared types, constants and table access functions for the breakpoint
// table interpolator. No dependencies.
package bti_pkg;

	// Number of table points in use (2 to 8).
	localparam int TABLE_POINTS = 8;
	localparam int LAST_POINT   = TABLE_POINTS - 1;
	// Binary search over TABLE_POINTS-1 segments needs this many probes.
	localparam int SEARCH_STEPS = $clog2(TABLE_POINTS);

	localparam int X_W   = 8;
	localparam int Y_W   = 16;
	localparam int IDX_W = 3;
	localparam int CFG_W = 64;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_X_BP  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_LOW = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_HIGH = 2'd2;

	// Status codes.
	localparam logic [1:0] ST_INTERP = 2'd0;
	localparam logic [1:0] ST_LOW    = 2'd1;
	localparam logic [1:0] ST_HIGH   = 2'd2;
	localparam logic [1:0] ST_ERROR  = 2'd3;

	localparam logic [Y_W-1:0] ERR_RESULT = 16'h00FF;

	// Divider geometry: the quotient is known to fit in Y_W bits.
	localparam int DIVD_W       = Y_W + X_W;
	localparam int DIV_BITS     = 4;
	localparam int DIV_STAGES   = Y_W / DIV_BITS;

	typedef struct packed {
		logic [1:0]     status;
		logic [Y_W-1:0] base;
		logic           neg;
	} side_t;

	typedef struct packed {
		logic [X_W-1:0] rem;
		logic [Y_W-1:0] work;
		logic [X_W-1:0] dx;
		side_t          side;
	} div_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] k;
	} seg_t;

	function automatic logic [X_W-1:0] bp_x(input logic [CFG_W-1:0] xb,
		input logic [IDX_W-1:0] idx);
		return xb[{idx, 3'b000} +: X_W];
	endfunction

	function automatic logic [Y_W-1:0] bp_y(input logic [CFG_W-1:0] ylo,
		input logic [CFG_W-1:0] yhi, input logic [IDX_W-1:0] idx);
		logic [CFG_W-1:0] reg_sel;
		reg_sel = idx[2] ? yhi : ylo;
		return reg_sel[{idx[1:0], 4'b0000} +: Y_W];
	endfunction

	// Binary search for the segment k with x[k] <= s < x[k+1].
	function automatic seg_t find_segment(input logic [CFG_W-1:0] xb,
		input logic [X_W-1:0] s);
		logic signed [4:0]  lo;
		logic signed [4:0]  hi;
		logic signed [4:0]  mid;
		logic [X_W-1:0]     xm;
		logic [X_W-1:0]     xn;
		seg_t               seg;
		lo  = 5'sd0;
		hi  = 5'(TABLE_POINTS - 2);
		seg = '0;
		for (int i = 0; i < SEARCH_STEPS; i++) begin
			if (!seg.found && lo <= hi) begin
				mid = lo + ((hi - lo) >>> 1);
				xm  = bp_x(xb, mid[IDX_W-1:0]);
				xn  = bp_x(xb, mid[IDX_W-1:0] + 3'd1);
				if (s >= xm && s < xn) begin
					seg.found = 1'b1;
					seg.k     = mid[IDX_W-1:0];
				end else if (xm < s) begin
					lo = mid + 5'sd1;
				end else begin
					hi = mid - 5'sd1;
				end
			end
		end
		return seg;
	endfunction

endpackage

// ===== hw/rtl/bti_div_stage.sv =====
// One registered slice of the restoring divider, DIV_BITS quotient bits.
// Depends on bti_pkg.
module bti_div_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  bti_pkg::div_t in_data,
	output logic          out_valid,
	output bti_pkg::div_t out_data
);

	bti_pkg::div_t nxt;
	logic          valid_s1;
	bti_pkg::div_t data_s1;

	// Shift the next dividend bit into the remainder and subtract the
	// divisor where it fits; quotient bits fill the work word from below.
	always_comb begin
		logic [bti_pkg::X_W:0] trial;
		logic                  qbit;
		nxt = in_data;
		for (int i = 0; i < bti_pkg::DIV_BITS; i++) begin
			trial = {nxt.rem, nxt.work[bti_pkg::Y_W-1]};
			if (trial >= {1'b0, nxt.dx}) begin
				nxt.rem = bti_pkg::X_W'(trial - {1'b0, nxt.dx});
				qbit    = 1'b1;
			end else begin
				nxt.rem = trial[bti_pkg::X_W-1:0];
				qbit    = 1'b0;
			end
			nxt.work = {nxt.work[bti_pkg::Y_W-2:0], qbit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

// ===== hw/rtl/breakpoint_table_interpolator.sv =====
// Breakpoint table interpolator, top level. Depends on bti_pkg, bti_div_stage
// and the assertion macros in breakpoint_table_interpolator_assert.svh.
//
// Each sample beat is mapped through an eight point piecewise linear table
// whose x breakpoints and y values sit in three 64-bit configuration
// registers. The block takes one sample per cycle and returns one result per
// sample, in order: stage one clamps and runs the three-probe binary search,
// stage two fetches the segment end points, stage three forms the 16 by 8 bit
// product, stages four to seven divide it by the segment width four quotient
// bits at a time, and stage eight adds the signed quotient to the segment base.
// The whole pipeline moves together and only halts while a finished result is
// held on the output by out_stall, so a sample is still taken in the cycle
// that the output is taken. Samples below the first breakpoint report status 1
// with the first y value, samples above or equal to the last breakpoint status
// 2 with the last y value, and a search that finds no segment (only possible
// with a table that is not increasing) reports status 3 with result 255.
// Configuration must only be written while no sample is in flight.
module breakpoint_table_interpolator (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [bti_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bti_pkg::CFG_W-1:0]          cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [bti_pkg::X_W-1:0]            sample,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [bti_pkg::Y_W-1:0]            result,
	output logic [1:0]                         status
);

	`include "breakpoint_table_interpolator_assert.svh"

	// Configuration registers.
	logic [bti_pkg::CFG_W-1:0] x_bp_q;
	logic [bti_pkg::CFG_W-1:0] y_lo_q;
	logic [bti_pkg::CFG_W-1:0] y_hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_bp_q <= '0;
			y_lo_q <= '0;
			y_hi_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bti_pkg::CFG_X_BP:   x_bp_q <= cfg_data;
				bti_pkg::CFG_Y_LOW:  y_lo_q <= cfg_data;
				bti_pkg::CFG_Y_HIGH: y_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The pipeline advances unless the output holds a beat that is stalled.
	logic en;
	logic valid_s8;

	assign en       = !(valid_s8 && out_stall);
	assign in_stall = !en;

	// Stage 1: range checks against the end breakpoints and segment search.
	logic                           valid_s1;
	logic [bti_pkg::X_W-1:0]        sample_s1;
	logic [bti_pkg::IDX_W-1:0]      k_s1;
	logic [1:0]                     status_s1;
	logic [bti_pkg::Y_W-1:0]        base_s1;

	bti_pkg::seg_t              seg;
	logic [bti_pkg::X_W-1:0]    x_first;
	logic [bti_pkg::X_W-1:0]    x_last;
	logic [1:0]                 status_c1;
	logic [bti_pkg::Y_W-1:0]    base_c1;

	assign x_first = bti_pkg::bp_x(x_bp_q, '0);
	assign x_last  = bti_pkg::bp_x(x_bp_q, bti_pkg::IDX_W'(bti_pkg::LAST_POINT));
	assign seg     = bti_pkg::find_segment(x_bp_q, sample);

	// The low clamp is checked first, then the high clamp, then the search.
	// A sample equal to the last breakpoint falls out of the search and is
	// treated as a high clamp.
	always_comb begin
		if (sample < x_first) begin
			status_c1 = bti_pkg::ST_LOW;
			base_c1   = bti_pkg::bp_y(y_lo_q, y_hi_q, '0);
		end else if (sample > x_last) begin
			status_c1 = bti_pkg::ST_HIGH;
			base_c1   = bti_pkg::bp_y(y_lo_q, y_hi_q,
				bti_pkg::IDX_W'(bti_pkg::LAST_POINT));
		end else if (seg.found) begin
			status_c1 = bti_pkg::ST_INTERP;
			base_c1   = '0;
		end else if (sample == x_last) begin
			status_c1 = bti_pkg::ST_HIGH;
			base_c1   = bti_pkg::bp_y(y_lo_q, y_hi_q,
				bti_pkg::IDX_W'(bti_pkg::LAST_POINT));
		end else begin
			status_c1 = bti_pkg::ST_ERROR;
			base_c1   = bti_pkg::ERR_RESULT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sample_s1 <= sample;
			k_s1      <= seg.k;
			status_s1 <= status_c1;
			base_s1   <= base_c1;
		end
	end

	// Stage 2: fetch the segment end points and form the slope operands.
	logic                        valid_s2;
	logic [bti_pkg::Y_W-1:0]     dy_mag_s2;
	logic [bti_pkg::X_W-1:0]     ds_s2;
	logic [bti_pkg::X_W-1:0]     dx_s2;
	bti_pkg::side_t              side_s2;

	logic [bti_pkg::Y_W-1:0]     y0_c2;
	logic [bti_pkg::Y_W-1:0]     y1_c2;
	logic [bti_pkg::X_W-1:0]     x0_c2;
	logic [bti_pkg::X_W-1:0]     x1_c2;
	logic [bti_pkg::Y_W:0]       dy_c2;
	logic [bti_pkg::Y_W:0]       dy_neg_c2;
	bti_pkg::side_t              side_c2;

	assign y0_c2     = bti_pkg::bp_y(y_lo_q, y_hi_q, k_s1);
	assign y1_c2     = bti_pkg::bp_y(y_lo_q, y_hi_q, k_s1 + 3'd1);
	assign x0_c2     = bti_pkg::bp_x(x_bp_q, k_s1);
	assign x1_c2     = bti_pkg::bp_x(x_bp_q, k_s1 + 3'd1);
	assign dy_c2     = {1'b0, y1_c2} - {1'b0, y0_c2};
	assign dy_neg_c2 = '0 - dy_c2;

	// For an interpolated sample the base is the lower end point, otherwise
	// it is the clamp or error value already chosen in stage one.
	always_comb begin
		side_c2.status = status_s1;
		side_c2.neg    = dy_c2[bti_pkg::Y_W];
		side_c2.base   = (status_s1 == bti_pkg::ST_INTERP) ? y0_c2 : base_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dy_mag_s2 <= dy_c2[bti_pkg::Y_W] ? dy_neg_c2[bti_pkg::Y_W-1:0]
				: dy_c2[bti_pkg::Y_W-1:0];
			ds_s2     <= sample_s1 - x0_c2;
			dx_s2     <= x1_c2 - x0_c2;
			side_s2   <= side_c2;
		end
	end

	// Stage 3: unsigned product of the slope magnitude and the offset.
	logic                          valid_s3;
	logic [bti_pkg::DIVD_W-1:0]    prod_s3;
	logic [bti_pkg::X_W-1:0]       dx_s3;
	bti_pkg::side_t                side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= bti_pkg::DIVD_W'(dy_mag_s2) * bti_pkg::DIVD_W'(ds_s2);
			dx_s3   <= dx_s2;
			side_s3 <= side_s2;
		end
	end

	// Stages 4 to 7: restoring division. Because the offset is below the
	// segment width the quotient fits in 16 bits, so the top byte of the
	// product is already smaller than the divisor and starts as remainder.
	logic [bti_pkg::DIV_STAGES:0] div_valid;
	bti_pkg::div_t                div_data [bti_pkg::DIV_STAGES+1];

	assign div_valid[0]         = valid_s3;
	assign div_data[0].rem      = prod_s3[bti_pkg::DIVD_W-1:bti_pkg::Y_W];
	assign div_data[0].work     = prod_s3[bti_pkg::Y_W-1:0];
	assign div_data[0].dx       = dx_s3;
	assign div_data[0].side     = side_s3;

	for (genvar g = 0; g < bti_pkg::DIV_STAGES; g++) begin : g_div
		bti_div_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (div_valid[g]),
			.in_data   (div_data[g]),
			.out_valid (div_valid[g+1]),
			.out_data  (div_data[g+1])
		);
	end

	// Stage 8: apply the sign of the slope and add the base; this is also
	// the output register.
	bti_pkg::div_t             div_last;
	logic [bti_pkg::Y_W-1:0]   quot;
	logic [bti_pkg::Y_W-1:0]   interp_c8;
	logic [bti_pkg::Y_W-1:0]   result_s8;
	logic [1:0]                status_s8;

	assign div_last  = div_data[bti_pkg::DIV_STAGES];
	assign quot      = div_last.work;
	assign interp_c8 = div_last.side.neg ? div_last.side.base - quot
		: div_last.side.base + quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
		end else if (en) begin
			valid_s8 <= div_valid[bti_pkg::DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			status_s8 <= div_last.side.status;
			result_s8 <= (div_last.side.status == bti_pkg::ST_INTERP) ? interp_c8
				: div_last.side.base;
		end
	end

	assign out_valid = valid_s8;
	assign result    = result_s8;
	assign status    = status_s8;

	// An accepted sample must enter the first stage.
	`BTI_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, valid_s1, "accepted beat lost")
	// A segment reported by the search is never zero wide.
	`BTI_ASSERT_SAME(a_dx_nonzero, valid_s2 && side_s2.status == bti_pkg::ST_INTERP, dx_s2 != '0, "zero segment width")
	// The starting remainder must be below the divisor or the quotient overflows.
	`BTI_ASSERT_SAME(a_div_range, valid_s3 && side_s3.status == bti_pkg::ST_INTERP, div_data[0].rem < dx_s3, "quotient overflow")
	// An error beat always carries the error value.
	`BTI_ASSERT_SAME(a_err_value, valid_s8 && status_s8 == bti_pkg::ST_ERROR, result_s8 == bti_pkg::ERR_RESULT, "bad error result")

endmodule
